FILE: design/bhtc_pkg.sv
`default_nettype none

package bhtc_pkg;

  // default hold counter width
  localparam int unsigned CountWidthDef = 16;

  // threshold register width and config port geometry
  localparam int unsigned TickW  = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  // register reset values
  localparam logic             ActiveLevelRst   = 1'b0;
  localparam logic [TickW-1:0] ToggleTicksRst   = 16'd1900;
  localparam logic [TickW-1:0] NetResetTicksRst = 16'd6900;
  localparam logic [TickW-1:0] FactoryTicksRst  = 16'd14900;
  localparam logic             ToggleEnableRst  = 1'b1;

  // pending flag bits
  localparam int unsigned FlagToggle = 0;
  localparam int unsigned FlagNet    = 1;
  localparam int unsigned FlagActive = 2;
  localparam logic [2:0]  FlagsAll   = 3'b111;
  localparam logic [2:0]  FlagsNone  = 3'b000;

  typedef enum logic [CfgIdxW-1:0] {
    RegActiveLevel   = 3'd0,
    RegToggleTicks   = 3'd1,
    RegNetResetTicks = 3'd2,
    RegFactoryTicks  = 3'd3,
    RegToggleEnable  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    TimedNone    = 2'd0,
    TimedToggle  = 2'd1,
    TimedNet     = 2'd2,
    TimedFactory = 2'd3
  } timed_e;

  typedef enum logic [2:0] {
    EdgeNone         = 3'd0,
    EdgePress        = 3'd1,
    EdgeReleasePlain = 3'd2,
    EdgeReleaseSave  = 3'd3,
    EdgeReleaseSleep = 3'd4
  } edge_e;

  typedef struct packed {
    logic             active_level;
    logic [TickW-1:0] toggle_ticks;
    logic [TickW-1:0] net_reset_ticks;
    logic [TickW-1:0] factory_ticks;
    logic             toggle_enable;
  } cfg_t;

  typedef struct packed {
    timed_e timed_event;
    edge_e  edge_event;
    logic   led_on;
    logic   display_unit;
  } res_t;

endpackage

`default_nettype wire

FILE: design/bhtc_cfg.sv
`default_nettype none

module bhtc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bhtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bhtc_pkg::CfgDataW-1:0] cfg_data_i,
  output bhtc_pkg::cfg_t                     cfg_o
);

  bhtc_pkg::cfg_t cfg_q;
  bhtc_pkg::cfg_t cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bhtc_pkg::RegActiveLevel:   cfg_d.active_level    = cfg_data_i[0];
        bhtc_pkg::RegToggleTicks:   cfg_d.toggle_ticks    = cfg_data_i[bhtc_pkg::TickW-1:0];
        bhtc_pkg::RegNetResetTicks: cfg_d.net_reset_ticks = cfg_data_i[bhtc_pkg::TickW-1:0];
        bhtc_pkg::RegFactoryTicks:  cfg_d.factory_ticks   = cfg_data_i[bhtc_pkg::TickW-1:0];
        bhtc_pkg::RegToggleEnable:  cfg_d.toggle_enable   = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level    <= bhtc_pkg::ActiveLevelRst;
      cfg_q.toggle_ticks    <= bhtc_pkg::ToggleTicksRst;
      cfg_q.net_reset_ticks <= bhtc_pkg::NetResetTicksRst;
      cfg_q.factory_ticks   <= bhtc_pkg::FactoryTicksRst;
      cfg_q.toggle_enable   <= bhtc_pkg::ToggleEnableRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/bhtc_core.sv
`default_nettype none

module bhtc_core #(
  parameter int unsigned COUNT_WIDTH = bhtc_pkg::CountWidthDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire logic    pin_i,
  input  bhtc_pkg::cfg_t cfg_i,
  output bhtc_pkg::res_t res_o
);

  localparam int unsigned CmpW =
    (COUNT_WIDTH > bhtc_pkg::TickW) ? COUNT_WIDTH : bhtc_pkg::TickW;

  logic                   was_pressed_q, was_pressed_d;
  logic [COUNT_WIDTH-1:0] held_q, held_d;
  logic [2:0]             flags_q, flags_d;
  logic                   unit_q, unit_d;

  logic       pressed;
  logic [2:0] flags_chk;
  logic [CmpW-1:0] held_x, fac_x, net_x, tog_x;

  assign pressed = (pin_i == cfg_i.active_level);
  assign held_x  = CmpW'(held_q);
  assign fac_x   = CmpW'(cfg_i.factory_ticks);
  assign net_x   = CmpW'(cfg_i.net_reset_ticks);
  assign tog_x   = CmpW'(cfg_i.toggle_ticks);

  // timed checks on previous state, then edge sampling
  always_comb begin
    res_o.timed_event = bhtc_pkg::TimedNone;
    res_o.edge_event  = bhtc_pkg::EdgeNone;
    flags_chk = flags_q;
    unit_d    = unit_q;
    if (flags_q != bhtc_pkg::FlagsNone) begin
      if (held_x > fac_x) begin
        res_o.timed_event = bhtc_pkg::TimedFactory;
        flags_chk = bhtc_pkg::FlagsNone;
      end else if (flags_q[bhtc_pkg::FlagNet] && (held_x > net_x)) begin
        res_o.timed_event = bhtc_pkg::TimedNet;
        flags_chk[bhtc_pkg::FlagNet] = 1'b0;
      end else if (cfg_i.toggle_enable && flags_q[bhtc_pkg::FlagToggle] &&
                   (held_x > tog_x)) begin
        res_o.timed_event = bhtc_pkg::TimedToggle;
        flags_chk[bhtc_pkg::FlagToggle] = 1'b0;
        unit_d = ~unit_q;
      end
    end

    flags_d = flags_chk;
    held_d  = held_q;
    if (pressed) begin
      if (!was_pressed_q) begin
        res_o.edge_event = bhtc_pkg::EdgePress;
        flags_d = bhtc_pkg::FlagsAll;
        held_d  = '0;
      end else if (!(&held_q)) begin
        held_d = held_q + COUNT_WIDTH'(1);
      end
    end else begin
      if (was_pressed_q) begin
        res_o.edge_event = bhtc_pkg::EdgeReleasePlain;
        if (flags_chk != bhtc_pkg::FlagsNone) begin
          if (!flags_chk[bhtc_pkg::FlagNet]) begin
            res_o.edge_event = bhtc_pkg::EdgeReleaseSleep;
          end else if (!flags_chk[bhtc_pkg::FlagToggle]) begin
            res_o.edge_event = bhtc_pkg::EdgeReleaseSave;
          end
        end
      end
      flags_d = bhtc_pkg::FlagsNone;
      held_d  = '0;
    end
    was_pressed_d      = pressed;
    res_o.led_on       = pressed;
    res_o.display_unit = unit_d;
  end

  // state update once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b0;
      held_q        <= '0;
      flags_q       <= bhtc_pkg::FlagsNone;
      unit_q        <= 1'b0;
    end else if (step_i) begin
      was_pressed_q <= was_pressed_d;
      held_q        <= held_d;
      flags_q       <= flags_d;
      unit_q        <= unit_d;
    end
  end

  // pending flags only live while the button is held
  a_flags_need_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q != bhtc_pkg::FlagsNone) |-> was_pressed_q)
    else $error("pending flags set while button released");

  // counter is cleared while released
  a_held_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !was_pressed_q |-> (held_q == '0))
    else $error("hold counter nonzero while released");

  // factory event leaves nothing pending
  a_factory_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res_o.timed_event == bhtc_pkg::TimedFactory)) |=>
      (flags_q == bhtc_pkg::FlagsNone))
    else $error("flags survive factory event");

  // unit bit flips exactly on a toggle event
  a_unit_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> ((unit_q != $past(unit_q)) ==
                ($past(res_o.timed_event) == bhtc_pkg::TimedToggle)))
    else $error("display unit changed without toggle event");

endmodule

`default_nettype wire

FILE: design/button_hold_time_classifier.sv
// an accepted request is held in the input register, then its result is registered in the output register
// throughput: one request per cycle while the output is not stalled; one tick of state update in a single pass
// a new request is taken while a finished result waits, held by the input register
// reset: asynchronous active low; clears state, valids and sets register defaults
// after reset: button released, no pending events, display unit 0
`default_nettype none

module button_hold_time_classifier #(
  parameter int unsigned COUNT_WIDTH = bhtc_pkg::CountWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          pin_level_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         timed_event_o,
  output logic [2:0]                         edge_event_o,
  output logic                               led_on_o,
  output logic                               display_unit_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bhtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [bhtc_pkg::CfgDataW-1:0] cfg_data_i
);

  bhtc_pkg::cfg_t cfg;
  bhtc_pkg::res_t res;
  bhtc_pkg::res_t res_q;

  logic s1_valid_q;
  logic s1_pin_q;
  logic out_valid_q;
  logic advance;
  logic step;

  // pipeline moves when the output register is free or drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign step       = s1_valid_q && advance;

  bhtc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bhtc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .pin_i  (s1_pin_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_pin_q <= pin_level_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign timed_event_o  = res_q.timed_event;
  assign edge_event_o   = res_q.edge_event;
  assign led_on_o       = res_q.led_on;
  assign display_unit_o = res_q.display_unit;

  // a stalled input register always has a blocked result ahead of it
  a_stall_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled with free output register");

  // press report always comes with the led on, release with it off
  a_led_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_q.edge_event == bhtc_pkg::EdgePress)) |-> led_on_o)
    else $error("press without led");

  a_led_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_q.edge_event != bhtc_pkg::EdgeNone) &&
     (res_q.edge_event != bhtc_pkg::EdgePress)) |-> !led_on_o)
    else $error("release with led on");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CountWidth = bhtc_pkg::CountWidthDef;
  localparam int unsigned MaxErrShown = 10;

  // register indexes the block must ignore
  localparam logic [bhtc_pkg::CfgIdxW-1:0] UnusedRegIdx [3] = '{3'd5, 3'd6, 3'd7};

  logic                          clk;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          pin_level_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [1:0]                    timed_event_o;
  logic [2:0]                    edge_event_o;
  logic                          led_on_o;
  logic                          display_unit_o;
  logic                          cfg_we_i;
  logic [bhtc_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [bhtc_pkg::CfgDataW-1:0] cfg_data_i;

  // classifier copy: configuration and tick state
  bhtc_pkg::cfg_t        cfg_q;
  logic                  pressed_q;
  logic [CountWidth-1:0] held_q;
  logic [2:0]            flags_q;
  logic                  unit_q;

  bhtc_pkg::res_t tick_results_q[$];
  int   mismatch_cnt;
  int   rx_wait;
  bit   tx_idle;
  bit   rx_idle;

  button_hold_time_classifier #(
    .COUNT_WIDTH(CountWidth)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pin_level_i   (pin_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .timed_event_o (timed_event_o),
    .edge_event_o  (edge_event_o),
    .led_on_o      (led_on_o),
    .display_unit_o(display_unit_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // one tick of the hold-time classifier, updates the local state
  function automatic bhtc_pkg::res_t classify_tick(input logic pin);
    logic             pressed;
    bhtc_pkg::timed_e timed;
    bhtc_pkg::edge_e  ev;
    bhtc_pkg::res_t   r;
    pressed = (pin == cfg_q.active_level);
    timed   = bhtc_pkg::TimedNone;
    ev      = bhtc_pkg::EdgeNone;
    // timed checks on the state left by the previous tick
    if (flags_q != bhtc_pkg::FlagsNone) begin
      if (held_q > cfg_q.factory_ticks) begin
        timed   = bhtc_pkg::TimedFactory;
        flags_q = bhtc_pkg::FlagsNone;
      end else if (flags_q[bhtc_pkg::FlagNet] && held_q > cfg_q.net_reset_ticks) begin
        timed                      = bhtc_pkg::TimedNet;
        flags_q[bhtc_pkg::FlagNet] = 1'b0;
      end else if (cfg_q.toggle_enable && flags_q[bhtc_pkg::FlagToggle] &&
                   held_q > cfg_q.toggle_ticks) begin
        timed                         = bhtc_pkg::TimedToggle;
        flags_q[bhtc_pkg::FlagToggle] = 1'b0;
        unit_q                        = ~unit_q;
      end
    end
    // press and release edges
    if (pressed) begin
      if (!pressed_q) begin
        ev      = bhtc_pkg::EdgePress;
        flags_q = bhtc_pkg::FlagsAll;
        held_q  = '0;
      end else if (held_q != '1) begin
        held_q = held_q + 1'b1;
      end
    end else begin
      if (pressed_q) begin
        ev = bhtc_pkg::EdgeReleasePlain;
        if (flags_q != bhtc_pkg::FlagsNone) begin
          if (!flags_q[bhtc_pkg::FlagNet]) begin
            ev = bhtc_pkg::EdgeReleaseSleep;
          end else if (!flags_q[bhtc_pkg::FlagToggle]) begin
            ev = bhtc_pkg::EdgeReleaseSave;
          end
        end
      end
      flags_q = bhtc_pkg::FlagsNone;
      held_q  = '0;
    end
    pressed_q      = pressed;
    r.timed_event  = timed;
    r.edge_event   = ev;
    r.led_on       = pressed;
    r.display_unit = unit_q;
    return r;
  endfunction

  // receiver stall, counted down at the falling edge
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    bhtc_pkg::res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tick_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxErrShown) begin
          $display("result with no request pending: timed %0d edge %0d led %0d unit %0d",
                   timed_event_o, edge_event_o, led_on_o, display_unit_o);
        end
      end else begin
        exp_r = tick_results_q.pop_front();
        if (timed_event_o !== exp_r.timed_event || edge_event_o !== exp_r.edge_event ||
            led_on_o !== exp_r.led_on || display_unit_o !== exp_r.display_unit) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxErrShown) begin
            $display("mismatch at %0t: timed %0d/%0d edge %0d/%0d led %0d/%0d unit %0d/%0d",
                     $realtime, exp_r.timed_event, timed_event_o, exp_r.edge_event,
                     edge_event_o, exp_r.led_on, led_on_o, exp_r.display_unit,
                     display_unit_o);
          end
        end
      end
      rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
    end
  end

  // send one tick request and record its expected result
  task automatic send_tick(input logic pin);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk); while (in_stall_o);
    tick_results_q.push_back(classify_tick(pin));
    @(negedge clk);
  endtask

  task automatic press_for(input int ticks);
    repeat (ticks) send_tick(cfg_q.active_level);
  endtask

  task automatic release_for(input int ticks);
    repeat (ticks) send_tick(~cfg_q.active_level);
  endtask

  // drain all pending results before touching registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bhtc_pkg::CfgIdxW-1:0] idx,
                           input logic [bhtc_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    @(negedge clk);
    case (idx)
      bhtc_pkg::RegActiveLevel:   cfg_q.active_level    = data[0];
      bhtc_pkg::RegToggleTicks:   cfg_q.toggle_ticks    = data;
      bhtc_pkg::RegNetResetTicks: cfg_q.net_reset_ticks = data;
      bhtc_pkg::RegFactoryTicks:  cfg_q.factory_ticks   = data;
      bhtc_pkg::RegToggleEnable:  cfg_q.toggle_enable   = data[0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [bhtc_pkg::TickW-1:0] toggle_t,
                                input logic [bhtc_pkg::TickW-1:0] net_t,
                                input logic [bhtc_pkg::TickW-1:0] factory_t);
    write_reg(bhtc_pkg::RegToggleTicks, toggle_t);
    write_reg(bhtc_pkg::RegNetResetTicks, net_t);
    write_reg(bhtc_pkg::RegFactoryTicks, factory_t);
  endtask

  // reset values: active low press, short hold with no timed event
  task automatic test_reset_defaults();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    release_for(3);
    press_for(20);
    release_for(2);
    wait_idle();
  endtask

  // every kind of release report
  task automatic test_release_kinds();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_reg(bhtc_pkg::RegActiveLevel, 16'd1);
    write_reg(bhtc_pkg::RegToggleEnable, 16'd1);
    set_thresholds(16'd2, 16'd5, 16'd9);
    release_for(1);
    press_for(1);
    release_for(1);
    press_for(5);
    release_for(1);
    press_for(8);
    release_for(1);
    press_for(12);
    release_for(1);
    wait_idle();
    write_reg(bhtc_pkg::RegToggleEnable, 16'd0);
    press_for(8);
    release_for(1);
    wait_idle();
  endtask

  // small ascending thresholds, all zero and all at maximum
  task automatic test_misordered();
    write_reg(bhtc_pkg::RegToggleEnable, 16'd1);
    set_thresholds(16'd0, 16'd1, 16'd3);
    press_for(7);
    release_for(1);
    wait_idle();
    set_thresholds(16'd0, 16'd0, 16'd0);
    press_for(3);
    release_for(1);
    wait_idle();
    set_thresholds(16'hffff, 16'hffff, 16'hffff);
    press_for(5);
    release_for(1);
    wait_idle();
  endtask

  // unused indexes ignored, one-bit registers masked
  task automatic test_bad_writes();
    foreach (UnusedRegIdx[i]) write_reg(UnusedRegIdx[i], 16'hffff);
    write_reg(bhtc_pkg::RegActiveLevel, 16'hfffe);
    write_reg(bhtc_pkg::RegToggleEnable, 16'hfffe);
    set_thresholds(16'd1, 16'd3, 16'd6);
    press_for(9);
    release_for(2);
    wait_idle();
    write_reg(bhtc_pkg::RegToggleEnable, 16'h0001);
    press_for(4);
    release_for(1);
    wait_idle();
  endtask

  function automatic logic [bhtc_pkg::TickW-1:0] pick_threshold();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return bhtc_pkg::TickW'($urandom_range(0, 24));
  endfunction

  // random configurations with mostly well-formed holds
  task automatic test_random(input int total);
    int sent;
    int n;
    int hold;
    int gap_ticks;
    sent = 0;
    while (sent < total) begin
      wait_idle();
      write_reg(bhtc_pkg::RegActiveLevel, bhtc_pkg::CfgDataW'($urandom));
      set_thresholds(pick_threshold(), pick_threshold(), pick_threshold());
      write_reg(bhtc_pkg::RegToggleEnable, bhtc_pkg::CfgDataW'($urandom));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      n = 0;
      while (n < 150) begin
        if ($urandom_range(0, 99) < 85) begin
          hold      = $urandom_range(1, 40);
          gap_ticks = $urandom_range(1, 4);
          press_for(hold);
          release_for(gap_ticks);
          n += hold + gap_ticks;
        end else begin
          hold = $urandom_range(1, 6);
          repeat (hold) send_tick(1'($urandom));
          n += hold;
        end
      end
      sent += n;
    end
    wait_idle();
  endtask

  initial begin
    in_valid_i   = 1'b0;
    pin_level_i  = 1'b0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = bhtc_pkg::RegActiveLevel;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    rx_wait      = 0;
    mismatch_cnt = 0;
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    cfg_q.active_level    = bhtc_pkg::ActiveLevelRst;
    cfg_q.toggle_ticks    = bhtc_pkg::ToggleTicksRst;
    cfg_q.net_reset_ticks = bhtc_pkg::NetResetTicksRst;
    cfg_q.factory_ticks   = bhtc_pkg::FactoryTicksRst;
    cfg_q.toggle_enable   = bhtc_pkg::ToggleEnableRst;
    pressed_q = 1'b0;
    held_q    = '0;
    flags_q   = bhtc_pkg::FlagsNone;
    unit_q    = 1'b0;
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk);

    test_reset_defaults();
    test_release_kinds();
    test_misordered();
    test_bad_writes();
    test_random(750);

    // drain and settle
    in_valid_i <= 1'b0;
    for (int i = 0; i < 2000 && tick_results_q.size() != 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (tick_results_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: button_hold_time_classifier.f
design/bhtc_pkg.sv
design/bhtc_cfg.sv
design/bhtc_core.sv
design/button_hold_time_classifier.sv
bench/tb.sv
